// ===== rtl/dttoi_pkg.sv =====
`default_nettype none

package dttoi_pkg;

	// Character classes decided by the front end
	typedef enum logic [2:0] {
		CLS_SPACE,
		CLS_MINUS,
		CLS_PLUS,
		CLS_DIGIT,
		CLS_TERM,
		CLS_OTHER
	} cls_t;

	// One classified character on its way to the accumulator
	typedef struct packed {
		cls_t       cls;
		logic [7:0] ch;
		logic [2:0] ttype;
	} item_t;

	// Error kinds reported with each result
	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_EMPTY    = 2'd1;
	localparam logic [1:0] ERR_INVALID  = 2'd2;
	localparam logic [1:0] ERR_OVERFLOW = 2'd3;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Target type after reset: signed 32 bit
	localparam logic [2:0] TYPE_RESET = 3'd2;

endpackage

`default_nettype wire

// ===== rtl/dttoi_front.sv =====
`default_nettype none

module dttoi_front
	import dttoi_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] ch,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] target_type,
	input  wire logic       q_full,
	output logic            q_push,
	output item_t           q_item
);

	logic [2:0] ttype_q;
	cls_t       cls;

	// Hold the target type register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttype_q <= TYPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ttype_q <= target_type;
		end
	end

	// Classify the incoming character
	always_comb begin
		if (ch == CH_NUL) begin
			cls = CLS_TERM;
		end else if (ch inside {[CH_TAB:CH_CR], CH_SPACE}) begin
			cls = CLS_SPACE;
		end else if (ch == CH_MINUS) begin
			cls = CLS_MINUS;
		end else if (ch == CH_PLUS) begin
			cls = CLS_PLUS;
		end else if (ch inside {[CH_ZERO:CH_NINE]}) begin
			cls = CLS_DIGIT;
		end else begin
			cls = CLS_OTHER;
		end
	end

	// Push each transfer into the queue with the type in force
	assign in_ready     = !q_full;
	assign q_push       = in_valid && in_ready;
	assign q_item.cls   = cls;
	assign q_item.ch    = ch;
	assign q_item.ttype = ttype_q;

endmodule

`default_nettype wire

// ===== rtl/dttoi_queue.sv =====
`default_nettype none

module dttoi_queue
	import dttoi_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output logic       not_empty,
	output item_t      head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t              mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && !not_empty))
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/dttoi_back.sv =====
`default_nettype none

module dttoi_back
	import dttoi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire item_t       q_item,
	output logic             q_pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      value,
	output logic [1:0]       error_kind,
	output logic [7:0]       bad_char
);

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_SIGN,
		PH_DIGITS,
		PH_TRAIL,
		PH_ERROR
	} phase_t;

	phase_t      phase_q,  phase_d;
	logic [63:0] mag_q,    mag_d;
	logic        neg_q,    neg_d;
	logic        ovf_q,    ovf_d;
	logic [1:0]  lerr_q,   lerr_d;
	logic [7:0]  lchar_q,  lchar_d;
	logic        out_valid_q, out_valid_d;
	logic [63:0] value_q,  value_d;
	logic [1:0]  err_q,    err_d;
	logic [7:0]  bad_q,    bad_d;

	logic        slot_free;
	logic        is_term;
	logic [67:0] prod;
	logic [63:0] lim;
	logic        oor;
	logic [7:0]  sign_char;

	assign slot_free = !out_valid_q || out_ready;
	assign is_term   = (q_item.cls == CLS_TERM);
	assign q_pop     = q_valid && (!is_term || slot_free);

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign error_kind = err_q;
	assign bad_char   = bad_q;

	// Multiply by ten and add the digit, four guard bits catch overflow
	assign prod = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {60'b0, q_item.ch[3:0]};

	// Pick the range limit of the target type
	always_comb begin
		case (q_item.ttype[1:0])
			2'd0: lim = q_item.ttype[2] ? 64'hFF :
				(neg_q ? 64'h80 : 64'h7F);
			2'd1: lim = q_item.ttype[2] ? 64'hFFFF :
				(neg_q ? 64'h8000 : 64'h7FFF);
			2'd2: lim = q_item.ttype[2] ? 64'hFFFF_FFFF :
				(neg_q ? 64'h8000_0000 : 64'h7FFF_FFFF);
			default: lim = q_item.ttype[2] ? 64'hFFFF_FFFF_FFFF_FFFF :
				(neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF);
		endcase
	end

	assign oor       = ovf_q || (mag_q > lim);
	assign sign_char = neg_q ? CH_MINUS : CH_PLUS;

	// Work out the next parse state and result
	always_comb begin
		phase_d     = phase_q;
		mag_d       = mag_q;
		neg_d       = neg_q;
		ovf_d       = ovf_q;
		lerr_d      = lerr_q;
		lchar_d     = lchar_q;
		out_valid_d = out_valid_q && !out_ready;
		value_d     = value_q;
		err_d       = err_q;
		bad_d       = bad_q;

		if (q_pop) begin
			if (is_term) begin
				out_valid_d = 1'b1;
				value_d     = '0;
				bad_d       = '0;
				if (phase_q == PH_LEAD) begin
					err_d = ERR_EMPTY;
				end else if (phase_q == PH_SIGN) begin
					err_d = ERR_INVALID;
					bad_d = sign_char;
				end else if (oor) begin
					err_d = ERR_OVERFLOW;
				end else if (lerr_q != ERR_OK) begin
					err_d = ERR_INVALID;
					bad_d = lchar_q;
				end else begin
					err_d   = ERR_OK;
					value_d = neg_q ? (64'd0 - mag_q) : mag_q;
				end
				// Drop the parse state for the next string
				phase_d = PH_LEAD;
				mag_d   = '0;
				neg_d   = 1'b0;
				ovf_d   = 1'b0;
				lerr_d  = ERR_OK;
				lchar_d = '0;
			end else begin
				case (phase_q)
					PH_LEAD: begin
						case (q_item.cls)
							CLS_SPACE: begin
							end
							CLS_MINUS: begin
								if (q_item.ttype[2]) begin
									lerr_d  = ERR_INVALID;
									lchar_d = q_item.ch;
									phase_d = PH_ERROR;
								end else begin
									neg_d   = 1'b1;
									phase_d = PH_SIGN;
								end
							end
							CLS_PLUS: begin
								phase_d = PH_SIGN;
							end
							CLS_DIGIT: begin
								phase_d = PH_DIGITS;
							end
							default: begin
								lerr_d  = ERR_INVALID;
								lchar_d = q_item.ch;
								phase_d = PH_ERROR;
							end
						endcase
					end
					PH_SIGN: begin
						if (q_item.cls == CLS_DIGIT) begin
							phase_d = PH_DIGITS;
						end else begin
							lerr_d  = ERR_INVALID;
							lchar_d = sign_char;
							phase_d = PH_ERROR;
						end
					end
					PH_DIGITS: begin
						if (q_item.cls == CLS_SPACE) begin
							phase_d = PH_TRAIL;
						end else if (q_item.cls != CLS_DIGIT) begin
							lerr_d  = ERR_INVALID;
							lchar_d = q_item.ch;
							phase_d = PH_ERROR;
						end
					end
					PH_TRAIL: begin
						if (q_item.cls != CLS_SPACE) begin
							lerr_d  = ERR_INVALID;
							lchar_d = q_item.ch;
							phase_d = PH_ERROR;
						end
					end
					default: begin
					end
				endcase

				// Accumulate a digit taken in lead, sign or digit phase
				if (q_item.cls == CLS_DIGIT && !ovf_q &&
					(phase_q == PH_LEAD || phase_q == PH_SIGN || phase_q == PH_DIGITS)) begin
					if (prod[67:64] != 4'b0) begin
						ovf_d = 1'b1;
					end else begin
						mag_d = prod[63:0];
					end
				end
			end
		end
	end

	// Hold parse state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			ovf_q       <= 1'b0;
			lerr_q      <= ERR_OK;
			lchar_q     <= '0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			err_q       <= ERR_OK;
			bad_q       <= '0;
		end else begin
			phase_q     <= phase_d;
			mag_q       <= mag_d;
			neg_q       <= neg_d;
			ovf_q       <= ovf_d;
			lerr_q      <= lerr_d;
			lchar_q     <= lchar_d;
			out_valid_q <= out_valid_d;
			value_q     <= value_d;
			err_q       <= err_d;
			bad_q       <= bad_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && err_q != ERR_OK |-> value_q == 64'd0)
		else $error("nonzero value with an error");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && err_q != ERR_INVALID |-> bad_q == 8'd0)
		else $error("bad character reported without invalid error");
	assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q && !(q_pop && is_term) |=> ovf_q)
		else $error("overflow flag lost mid-string");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERROR) == (lerr_q == ERR_INVALID))
		else $error("error phase and latched error disagree");

endmodule

`default_nettype wire

// ===== rtl/decimal_text_to_integer.sv =====
`default_nettype none

// Decimal text to integer converter. Characters arrive one per transfer on
// ch; a zero byte ends the string and yields exactly one result (value,
// error_kind, bad_char), all other characters yield none. Leading and
// trailing whitespace is skipped, one sign is accepted, and the digits are
// accumulated with a sticky overflow flag and range-checked against the
// type in target_type (0..3 signed 8/16/32/64, 4..7 unsigned; reset 2).
// The block takes one character per clock cycle while the output is not
// stalled; a result is registered once its terminator leaves the queue.
// The accumulator sets the rate, one multiply-by-ten and add per cycle; a
// small queue between classifier and accumulator absorbs output stalls.
// Write target_type only while no string is in flight.
module decimal_text_to_integer
	import dttoi_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  ch,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      value,
	output logic [1:0]       error_kind,
	output logic [7:0]       bad_char,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  target_type
);

	logic  q_full;
	logic  q_push;
	item_t q_in;
	logic  q_pop;
	logic  q_valid;
	item_t q_head;

	dttoi_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ch          (ch),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.target_type (target_type),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_in)
	);

	dttoi_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	dttoi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.error_kind (error_kind),
		.bad_char   (bad_char)
	);

endmodule

`default_nettype wire
